/* rtl/core/qph_pkg.sv */
// ----------------------------------------------------------------------------
// qph_pkg
// Shared types and constants of the quadratic probe hash table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qph_pkg;

    localparam int KEY_W     = 31;
    localparam int VALUE_W   = 64;
    localparam int LEN_W     = 11;
    localparam int INDEX_W   = 10;
    localparam int STATUS_W  = 2;

    localparam int SLOTS_DEF      = 1024;
    localparam int VALUE_BITS_DEF = 64;
    localparam int LEN_RESET      = 1024;

    // The key remainder is formed from a 32-bit padded key, four bits a cycle.
    localparam int MOD_KEY_W = 32;
    localparam int MOD_STEP  = 4;
    localparam int MOD_CYC   = MOD_KEY_W / MOD_STEP;
    localparam int MOD_CNT_W = $clog2(MOD_CYC);

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode            opcode;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] slot_index;
        logic [VALUE_W-1:0] found_value;
    } t_out_item;

endpackage : qph_pkg

`default_nettype wire

/* rtl/core/quadratic_probe_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_unit
// Open-addressing hash table with quadratic probing, slots held in one
// synchronous memory of used bit, key and value.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Signals                              Carries
//  -------  ---------  -----------------------------------  ------------------
//  cfg      in         i_cfg_valid  o_cfg_ready  i_cfg_data  table_len
//  in       in         i_in_valid   o_in_ready   i_in_data   t_in_item
//  out      out        o_out_valid  i_out_ready  o_out_data  t_out_item
//
//  An operation passes through one accept step, the key remainder (4 bits a
//  cycle), one first read, P probes on the memory port (P from 1 to
//  table_len) and one result step.
//  After reset the table is swept empty, during which no item is taken;
//  configuration transfers are taken in every cycle.
//  A stalled output holds its result; the next item is already accepted and
//  waits in its result state until the output register is free.
//
`default_nettype none

module quadratic_probe_hash_table_unit
    import qph_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,

    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [LEN_W-1:0] i_cfg_data,

    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_item         i_in_data,

    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_item             o_out_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int AW = IW + 1;
    localparam int MW = 1 + KEY_W + VALUE_BITS;
    localparam int LEN_RST = (LEN_RESET < SLOTS) ? LEN_RESET : SLOTS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RD0,
        S_PROBE,
        S_FIN
    } t_state;

    t_state                 r_state,    n_state;
    logic [LW-1:0]          r_len,      n_len;
    logic [IW-1:0]          r_clr,      n_clr;
    t_opcode                r_op,       n_op;
    logic [KEY_W-1:0]       r_key,      n_key;
    logic [VALUE_BITS-1:0]  r_value,    n_value;
    logic [MOD_KEY_W-1:0]   r_kshift,   n_kshift;
    logic [MOD_CNT_W-1:0]   r_cnt,      n_cnt;
    logic [IW-1:0]          r_probe,    n_probe;
    logic [IW-1:0]          r_inc,      n_inc;
    logic [LW-1:0]          r_try,      n_try;
    t_out_item              r_res,      n_res;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out,      n_out;

    logic [MW-1:0]          mem [SLOTS];
    logic [MW-1:0]          r_rd_word;
    logic                   mem_we;
    logic [IW-1:0]          mem_wa;
    logic [MW-1:0]          mem_wd;
    logic [IW-1:0]          mem_ra;

    logic                   rd_used;
    logic [KEY_W-1:0]       rd_key;
    logic [VALUE_BITS-1:0]  rd_value;
    logic [AW-1:0]          len_a;
    logic [AW-1:0]          p_sum;
    logic [IW-1:0]          p_next;
    logic [AW-1:0]          inc_sum;
    logic [IW-1:0]          inc_next;
    logic                   last_try;
    logic [31:0]            probe_ext;
    logic [31:0]            cfg_ext;
    logic [AW-1:0]          m_rem;

    assign rd_used  = r_rd_word[MW-1];
    assign rd_key   = r_rd_word[MW-2 -: KEY_W];
    assign rd_value = r_rd_word[VALUE_BITS-1:0];

    assign len_a     = AW'(r_len);
    assign p_sum     = {1'b0, r_probe} + AW'(r_inc);
    assign p_next    = (p_sum >= len_a) ? IW'(p_sum - len_a) : IW'(p_sum);
    assign inc_sum   = AW'(r_inc) + AW'(2);
    assign last_try  = (r_try == (r_len - LW'(1)));
    assign probe_ext = 32'(r_probe);
    assign cfg_ext   = 32'(i_cfg_data);

    // The step from try t to t+1 adds 2(t+1), kept reduced below the length.
    always_comb begin
        if (r_len == LW'(1)) begin
            inc_next = '0;
        end else if (inc_sum >= len_a) begin
            inc_next = IW'(inc_sum - len_a);
        end else begin
            inc_next = IW'(inc_sum);
        end
    end

    // Restoring remainder of the key by the table length, MOD_STEP bits a cycle.
    always_comb begin
        m_rem = {1'b0, r_probe};
        for (int i = 0; i < MOD_STEP; i++) begin
            m_rem = {m_rem[IW-1:0], r_kshift[MOD_KEY_W-1-i]};
            if (m_rem >= len_a) begin
                m_rem = m_rem - len_a;
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_clr       = r_clr;
        n_op        = r_op;
        n_key       = r_key;
        n_value     = r_value;
        n_kshift    = r_kshift;
        n_cnt       = r_cnt;
        n_probe     = r_probe;
        n_inc       = r_inc;
        n_try       = r_try;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_wa      = r_probe;
        mem_wd      = {1'b1, r_key, r_value};
        mem_ra      = r_probe;

        if (i_cfg_valid) begin
            if (cfg_ext == 32'd0) begin
                n_len = LW'(1);
            end else if (cfg_ext > 32'(SLOTS)) begin
                n_len = LW'(SLOTS);
            end else begin
                n_len = LW'(cfg_ext);
            end
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
                n_clr  = r_clr + IW'(1);
                if (r_clr == IW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in_data.opcode;
                    n_key    = i_in_data.key;
                    n_value  = i_in_data.value[VALUE_BITS-1:0];
                    n_kshift = MOD_KEY_W'(i_in_data.key);
                    n_cnt    = '0;
                    n_probe  = '0;
                    n_try    = '0;
                    n_inc    = (r_len <= LW'(2)) ? '0 : IW'(2);
                    n_state  = S_MOD;
                end
            end
            S_MOD: begin
                n_probe  = IW'(m_rem);
                n_kshift = r_kshift << MOD_STEP;
                n_cnt    = r_cnt + MOD_CNT_W'(1);
                if (r_cnt == MOD_CNT_W'(MOD_CYC - 1)) begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                n_state = S_PROBE;
            end
            S_PROBE: begin
                // Read data belongs to r_probe; the next probe's slot is read in the
                // same cycle as this check.
                n_res.slot_index  = '0;
                n_res.found_value = '0;
                n_state           = S_FIN;
                if (r_op == OP_INSERT) begin
                    if (!rd_used) begin
                        mem_we           = 1'b1;
                        n_res.status     = ST_INSERTED;
                        n_res.slot_index = probe_ext[INDEX_W-1:0];
                    end else if (last_try) begin
                        n_res.status = ST_FULL;
                    end else begin
                        n_state = S_PROBE;
                    end
                end else begin
                    if (!rd_used) begin
                        n_res.status = ST_MISSING;
                    end else if (rd_key == r_key) begin
                        n_res.status      = ST_FOUND;
                        n_res.slot_index  = probe_ext[INDEX_W-1:0];
                        n_res.found_value = VALUE_W'(rd_value);
                    end else if (last_try) begin
                        n_res.status = ST_MISSING;
                    end else begin
                        n_state = S_PROBE;
                    end
                end
                if (n_state == S_PROBE) begin
                    n_probe = p_next;
                    n_inc   = inc_next;
                    n_try   = r_try + LW'(1);
                    mem_ra  = p_next;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_len       <= LW'(LEN_RST);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_op        <= n_op;
            r_key       <= n_key;
            r_value     <= n_value;
            r_kshift    <= n_kshift;
            r_cnt       <= n_cnt;
            r_probe     <= n_probe;
            r_inc       <= n_inc;
            r_try       <= n_try;
            r_res       <= n_res;
            r_out       <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_word <= mem[mem_ra];
    end

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (AW'(r_probe) < len_a && AW'(r_inc) < len_a))
        else $error("probe slot or step outside the table length");

    a_try_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_try < r_len))
        else $error("try count reached the table length");

    a_write_insert_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != S_CLEAR) |-> (r_op == OP_INSERT && !rd_used))
        else $error("slot written outside an insert into an empty slot");

    a_found_on_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_res.status == ST_FOUND) |-> (r_op == OP_SEARCH))
        else $error("found status on an insert");

    a_no_ready_while_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (!o_out_valid || $past(o_out_valid)))
        else $error("result produced during the clearing sweep");

endmodule : quadratic_probe_hash_table_unit

`default_nettype wire
